### sv/nsqrt_pkg.sv
// ============================================================================
// nsqrt_pkg: shared constants for the Newton square root block
// Field widths, register indexes and reset values of the configuration.
// ============================================================================
package nsqrt_pkg;
    localparam int FRAC_BITS     = 16;
    localparam int RADICAND_BITS = 31;
    localparam int RAD_W         = 31;
    localparam int ROOT_W        = 32;
    localparam int STEP_W        = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_GUESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd2;

    localparam logic [31:0] INIT_GUESS_RST = 32'h0001_0000;
    localparam logic [31:0] TOLERANCE_RST  = 32'd4295;
    localparam logic [6:0]  ITER_LIMIT_RST = 7'd32;
endpackage

### sv/nsqrt_in_if.sv
// ============================================================================
// nsqrt_in_if: radicand request channel
// Valid/ready handshake carrying one radicand.
// ============================================================================
interface nsqrt_in_if;
    logic                               valid;
    logic                               ready;
    logic [nsqrt_pkg::RAD_W-1:0]        radicand;
    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);
endinterface

### sv/nsqrt_out_if.sv
// ============================================================================
// nsqrt_out_if: result channel
// Valid/ready handshake carrying root, converged flag and step count.
// ============================================================================
interface nsqrt_out_if;
    logic                               valid;
    logic                               ready;
    logic [nsqrt_pkg::ROOT_W-1:0]       root;
    logic                               converged;
    logic [nsqrt_pkg::STEP_W-1:0]       steps_taken;
    modport source (output valid, output root, output converged, output steps_taken,
                    input ready);
    modport sink   (input valid, input root, input converged, input steps_taken,
                    output ready);
endinterface

### sv/newton_square_root.sv
// ============================================================================
// newton_square_root: Newton-Raphson square root in unsigned fixed point
// Iterates g = (g + x/g)/2 until |g*g - x| is below the tolerance or the
// step limit is reached. Divider and multiplier both work one bit a cycle.
// ============================================================================
//  channel   | direction | contents
//  i_in      | request   | radicand
//  o_out     | result    | root, converged, steps_taken
//  i_cfg_*   | write     | initial_guess, tolerance, iteration_limit
//
// Each check is a shift-add square followed by a compare state.
// Each Newton step is a restoring division over the RADICAND_BITS+2*FRAC_BITS
// dividend bits, followed by an update state. One item is worked at a time.
// The result register holds until taken; a new request is taken meanwhile.
// Reset is synchronous and active low and clears only control state and the configuration registers.
module newton_square_root #(
    parameter int FRAC_BITS     = nsqrt_pkg::FRAC_BITS,
    parameter int RADICAND_BITS = nsqrt_pkg::RADICAND_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    nsqrt_in_if.sink                            i_in,
    nsqrt_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [nsqrt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nsqrt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int TWO_F  = 2 * FRAC_BITS;
    localparam int NBITS  = RADICAND_BITS + TWO_F;
    localparam int PW     = 64;
    localparam int DCNT_W = $clog2(NBITS + 1);
    localparam int MCNT_W = 6;
    localparam int QW     = 34;
    localparam logic [QW-1:0] QUOT_CAP = {QW{1'b1}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;

    // Configuration registers.
    logic [31:0] r_init_guess, r_tolerance;
    logic [6:0]  r_iter_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_guess <= nsqrt_pkg::INIT_GUESS_RST;
            r_tolerance  <= nsqrt_pkg::TOLERANCE_RST;
            r_iter_limit <= nsqrt_pkg::ITER_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nsqrt_pkg::REG_INIT_GUESS: r_init_guess <= i_cfg_data;
                nsqrt_pkg::REG_TOLERANCE:  r_tolerance  <= i_cfg_data;
                nsqrt_pkg::REG_ITER_LIMIT: r_iter_limit <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [2:0]        r_state;
    logic [31:0]       r_x;
    logic [31:0]       r_g;
    logic [6:0]        r_steps;
    logic [PW-1:0]     r_prod;
    logic [31:0]       r_mcand;
    logic [MCNT_W-1:0] r_mcnt;
    logic [NBITS-1:0]  r_dividend;
    logic [31:0]       r_rem;
    logic [QW-1:0]     r_quot;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_out_valid;
    logic [31:0]       r_out_root;
    logic              r_out_conv;
    logic [6:0]        r_out_steps;

    logic [PW-1:0] prod_add;
    logic [PW-1:0] ip, fr_full;
    logic [31:0]   fr;
    logic          close;
    logic [32:0]   rem_sh, rem_sub;
    logic          rem_ge;
    logic [QW-1:0] quot_sh;
    logic [QW:0]   g_sum;
    logic [31:0]   new_g;
    logic          done_item;

    // Shift-add square: one multiplier bit per cycle, MSB first.
    assign prod_add = {r_prod[PW-2:0], 1'b0} + (r_mcand[31] ? {32'd0, r_g} : '0);

    // Distance check of the finished square against the radicand.
    always_comb begin
        ip      = r_prod >> TWO_F;
        fr_full = r_prod & ((64'd1 << TWO_F) - 64'd1);
        fr      = 32'((TWO_F >= 32) ? (fr_full >> (TWO_F - 32)) : (fr_full << (32 - TWO_F)));
        if (ip >= {32'd0, r_x})  close = (ip == {32'd0, r_x}) && (fr < r_tolerance);
        else if (fr == 32'd0)    close = 1'b0;
        else close = (ip + 64'd1 == {32'd0, r_x}) && ((33'h1_0000_0000 - {1'b0, fr})
                     < {1'b0, r_tolerance});
    end

    // Restoring division step: one quotient bit per cycle, quotient capped.
    assign rem_sh  = {r_rem, r_dividend[NBITS-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_g};
    assign rem_sub = rem_ge ? rem_sh - {1'b0, r_g} : rem_sh;
    assign quot_sh = r_quot[QW-1] ? QUOT_CAP : {r_quot[QW-2:0], rem_ge};

    // Halved sum with saturation.
    assign g_sum = {1'b0, r_quot} + {3'd0, r_g};
    assign new_g = (|g_sum[QW:33]) ? 32'hFFFF_FFFF : g_sum[32:1];

    assign i_in.ready = (r_state == ST_IDLE);
    assign done_item  = (r_state == ST_CMP) && (close || (r_steps >= r_iter_limit));

    // Iteration sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: if (i_in.valid) r_state <= ST_MUL;
                ST_MUL:  if (r_mcnt == MCNT_W'(31)) r_state <= ST_CMP;
                ST_CMP: begin
                    if (done_item) begin
                        if (!r_out_valid || o_out.ready) r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV:  if (r_dcnt == DCNT_W'(NBITS - 1)) r_state <= ST_UPD;
                ST_UPD:  r_state <= ST_MUL;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_x     <= 32'(i_in.radicand[RADICAND_BITS-1:0]);
                r_g     <= r_init_guess;
                r_mcand <= r_init_guess;
                r_steps <= '0;
                r_prod  <= '0;
                r_mcnt  <= '0;
            end
            ST_MUL: begin
                r_prod  <= prod_add;
                r_mcand <= {r_mcand[30:0], 1'b0};
                r_mcnt  <= r_mcnt + MCNT_W'(1);
            end
            ST_CMP: begin
                r_dividend <= NBITS'(r_x) << TWO_F;
                r_rem      <= '0;
                r_quot     <= '0;
                r_dcnt     <= '0;
            end
            ST_DIV: begin
                r_dividend <= {r_dividend[NBITS-2:0], 1'b0};
                r_rem      <= rem_sub[31:0];
                r_quot     <= quot_sh;
                r_dcnt     <= r_dcnt + DCNT_W'(1);
            end
            ST_UPD: begin
                r_g     <= new_g;
                r_mcand <= new_g;
                r_steps <= r_steps + 7'd1;
                r_prod  <= '0;
                r_mcnt  <= '0;
            end
            default: ;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_item && (!r_out_valid || o_out.ready)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_item && (!r_out_valid || o_out.ready)) begin
            r_out_root  <= r_g;
            r_out_conv  <= close;
            r_out_steps <= r_steps;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.root        = r_out_root;
    assign o_out.converged   = r_out_conv;
    assign o_out.steps_taken = r_out_steps;
endmodule

### verif/tb_newton_square_root.sv
// ============================================================================
// tb_newton_square_root: self-checking bench for the Newton square root block
// A bit-exact fixed-point predictor computes root, converged flag and step
// count for every accepted radicand. The scoreboard compares each result with
// the oldest prediction. Directed corners are followed by random phases that
// vary all three registers, with random stalls on both channels.
// ============================================================================
module tb_newton_square_root;

    localparam int    CYCLE_LIMIT = 20_000_000;
    localparam logic [63:0] QUOT_CAP = 64'h3_FFFF_FFFF;

    typedef struct packed {
        logic [nsqrt_pkg::ROOT_W-1:0] root;
        logic                         converged;
        logic [nsqrt_pkg::STEP_W-1:0] steps_taken;
    } t_sqrt_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [nsqrt_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [nsqrt_pkg::CFG_DATA_W-1:0] i_cfg_data;

    nsqrt_in_if  in_ch ();
    nsqrt_out_if out_ch ();

    newton_square_root dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [31:0] guess_start;
    logic [31:0] tol_bound;
    logic [6:0]  step_cap;

    t_sqrt_result pending_roots[$];
    int unsigned  mismatch_count;
    int unsigned  cycle_count;
    bit           steady_flow;

    // Clock generation.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Run-time guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Is |g*g - x| below the bound, measured at 32 fractional bits?
    function automatic bit within_bound(logic [63:0] g, logic [63:0] x, logic [63:0] tol);
        logic [63:0] sq;
        logic [63:0] ip;
        logic [63:0] fr;
        logic [63:0] dh;
        logic [63:0] dl;
        sq = g * g;
        ip = sq >> 32;
        fr = {32'd0, sq[31:0]};
        if (ip >= x) begin
            dh = ip - x;
            dl = fr;
        end else if (fr == 0) begin
            dh = x - ip;
            dl = 0;
        end else begin
            dh = x - ip - 1;
            dl = 64'h1_0000_0000 - fr;
        end
        return (dh == 0) && (dl < tol);
    endfunction

    // floor(x * 2^32 / g) bit by bit, the quotient capped.
    function automatic logic [63:0] scaled_quotient(logic [63:0] x, logic [63:0] g);
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] nbit;
        rem = 0;
        quo = 0;
        for (int pos = nsqrt_pkg::RADICAND_BITS + 2 * nsqrt_pkg::FRAC_BITS - 1; pos >= 0;
             pos--) begin
            nbit = (pos >= 2 * nsqrt_pkg::FRAC_BITS)
                 ? ((x >> (pos - 2 * nsqrt_pkg::FRAC_BITS)) & 64'd1) : 64'd0;
            rem = (rem << 1) | nbit;
            quo = quo << 1;
            if (rem >= g) begin
                rem = rem - g;
                quo = quo | 64'd1;
            end
            if (quo > QUOT_CAP)
                quo = QUOT_CAP;
        end
        return quo;
    endfunction

    // Newton iteration as the block performs it.
    function automatic t_sqrt_result newton_root(logic [nsqrt_pkg::RAD_W-1:0] radicand);
        t_sqrt_result res;
        logic [63:0] x;
        logic [63:0] g;
        logic [63:0] ng;
        int unsigned steps;
        bit          conv;
        x = {33'd0, radicand};
        g = {32'd0, guess_start};
        steps = 0;
        conv = 1'b0;
        forever begin
            if (within_bound(g, x, {32'd0, tol_bound})) begin
                conv = 1'b1;
                break;
            end
            if (steps >= step_cap)
                break;
            ng = (g + scaled_quotient(x, g)) >> 1;
            g = (ng > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : ng;
            steps++;
        end
        res.root        = g[31:0];
        res.converged   = conv;
        res.steps_taken = steps[nsqrt_pkg::STEP_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("[%0d] mismatch on %s: got 0x%0h, want 0x%0h", cycle_count, field, got, want);
        mismatch_count++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_roots.size() == 0) begin
                report_mismatch("unexpected result root", out_ch.root, 0);
            end else begin
                t_sqrt_result want;
                want = pending_roots.pop_front();
                if (out_ch.root !== want.root)
                    report_mismatch("root", out_ch.root, want.root);
                if (out_ch.converged !== want.converged)
                    report_mismatch("converged", out_ch.converged, want.converged);
                if (out_ch.steps_taken !== want.steps_taken)
                    report_mismatch("steps_taken", out_ch.steps_taken, want.steps_taken);
            end
        end
    end

    // Result-side backpressure.
    always @(posedge i_clk) begin
        out_ch.ready <= steady_flow || ($urandom_range(99) >= 21);
    end

    // Send one radicand request; valid stays high when the next one follows.
    task automatic send_radicand(logic [nsqrt_pkg::RAD_W-1:0] radicand);
        if (!steady_flow && $urandom_range(99) < 21) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.radicand <= radicand;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_roots.push_back(newton_root(radicand));
    endtask

    task automatic drain_results();
        while (pending_roots.size() != 0) @(posedge i_clk);
    endtask

    // Register write, only with the block idle.
    task automatic write_register(logic [nsqrt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        in_ch.valid <= 1'b0;
        drain_results();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            nsqrt_pkg::REG_INIT_GUESS: guess_start = value;
            nsqrt_pkg::REG_TOLERANCE:  tol_bound   = value;
            nsqrt_pkg::REG_ITER_LIMIT: step_cap    = value[6:0];
            default: ;
        endcase
    endtask

    function automatic logic [nsqrt_pkg::RAD_W-1:0] random_radicand();
        case ($urandom_range(3))
            0:       return nsqrt_pkg::RAD_W'($urandom_range(255));
            1:       return nsqrt_pkg::RAD_W'($urandom_range(65535));
            default: return nsqrt_pkg::RAD_W'($urandom);
        endcase
    endfunction

    // Corners at the reset configuration.
    task automatic test_reset_defaults();
        logic [nsqrt_pkg::RAD_W-1:0] corners[10] = '{0, 1, 2, 3, 4, 100, 65536,
                                                     31'h4000_0000, 31'h2AAA_AAAA,
                                                     31'h7FFF_FFFF};
        foreach (corners[k]) send_radicand(corners[k]);
    endtask

    // Zero tolerance runs to the limit; a huge tolerance stops once the square is within one of the radicand.
    task automatic test_tolerance_extremes();
        write_register(nsqrt_pkg::REG_ITER_LIMIT, 32'd1);
        write_register(nsqrt_pkg::REG_TOLERANCE, 32'd0);
        send_radicand(31'd9);
        send_radicand(31'h5555_5555);
        write_register(nsqrt_pkg::REG_ITER_LIMIT, 32'd64);
        send_radicand(31'd2);
        write_register(nsqrt_pkg::REG_TOLERANCE, 32'hFFFF_FFFF);
        send_radicand(31'd0);
        send_radicand(31'd1);
        send_radicand(31'd2);
    endtask

    // Tiny and huge starting guesses; the tiny one saturates the update.
    task automatic test_guess_extremes();
        write_register(nsqrt_pkg::REG_TOLERANCE, nsqrt_pkg::TOLERANCE_RST);
        write_register(nsqrt_pkg::REG_INIT_GUESS, 32'd1);
        send_radicand(31'h7FFF_FFFF);
        send_radicand(31'd5);
        write_register(nsqrt_pkg::REG_INIT_GUESS, 32'hFFFF_FFFF);
        send_radicand(31'd0);
        send_radicand(31'h7FFF_FFFF);
        write_register(nsqrt_pkg::REG_INIT_GUESS, 32'h0003_0000);
        send_radicand(31'd9);
    endtask

    // Random phases over all registers.
    task automatic test_random_phases(int unsigned items);
        int unsigned sent;
        sent = 0;
        while (sent < items) begin
            write_register(nsqrt_pkg::REG_INIT_GUESS,
                           ($urandom_range(3) == 0) ? $urandom | 32'd1
                                                    : 32'($urandom_range(1, 32'h0100_0000)));
            write_register(nsqrt_pkg::REG_TOLERANCE,
                           ($urandom_range(4) == 0) ? $urandom
                                                    : 32'($urandom_range(0, 100000)));
            write_register(nsqrt_pkg::REG_ITER_LIMIT,
                           ($urandom_range(9) == 0) ? 32'd64
                                                    : 32'($urandom_range(1, 16)));
            repeat ($urandom_range(10, 40)) begin
                send_radicand(random_radicand());
                sent++;
            end
        end
    endtask

    // Sender holds off until every result is back, then a burst without stalls.
    task automatic test_drain_and_burst();
        send_radicand(random_radicand());
        in_ch.valid <= 1'b0;
        drain_results();
        steady_flow = 1'b1;
        repeat (30) send_radicand(random_radicand());
        steady_flow = 1'b0;
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= nsqrt_pkg::REG_INIT_GUESS;
        i_cfg_data     <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.radicand <= '0;
        mismatch_count = 0;
        cycle_count    = 0;
        steady_flow    = 1'b0;
        guess_start    = nsqrt_pkg::INIT_GUESS_RST;
        tol_bound      = nsqrt_pkg::TOLERANCE_RST;
        step_cap       = nsqrt_pkg::ITER_LIMIT_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_tolerance_extremes();
        test_guess_extremes();
        test_random_phases(440);
        test_drain_and_burst();

        in_ch.valid <= 1'b0;
        drain_results();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### newton_square_root.f
sv/nsqrt_pkg.sv
sv/nsqrt_in_if.sv
sv/nsqrt_out_if.sv
sv/newton_square_root.sv
verif/tb_newton_square_root.sv
